// ----- hw/rtl/scalar_kalman_filter_macros.svh -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_macros: assertion macros for the scalar Kalman filter
// Clocked property checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define SKF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SKF_ASSERT(lbl, clk, rst, prop, msg)
`define SKF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/skf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants
// Controller states, command and status bundles, register map.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 4;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 4'd1;

  // reset values (0.03 and 15.0 in unsigned Q8.16)
  localparam logic [CFG_W-1:0] Q_RESET = 24'd1966;
  localparam logic [CFG_W-1:0] R_RESET = 24'd983040;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DINIT,
    S_DIV,
    S_MULK,
    S_UPD_EST,
    S_UPD_VAR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture sample, form p and innovation
    logic dinit;     // form p + R, seed divider
    logic div_step;  // one restoring division step
    logic mul_est;   // innovation * gain
    logic upd_est;   // write estimate, start p * (1 - k)
    logic upd_var;   // write variance
    logic out_load;  // copy estimate to output register
  } cmd_t;

  typedef struct packed {
    logic div_last;  // current division step is the final one
  } status_t;

endpackage

// ----- hw/rtl/skf_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_datapath: arithmetic and state of the scalar Kalman filter
// Config registers, bit-serial gain divider, shared multiplier, saturation.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_macros.svh"

module skf_datapath
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [DATA_W-1:0]    measurement,
  output logic [DATA_W-1:0]    estimate
);

  localparam int PW = FRAC_BITS + 35;             // product width
  localparam int CW = $clog2(FRAC_BITS + 1);      // division step counter
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = $signed(PW'(1) << (FRAC_BITS - 1));

  logic [CFG_W-1:0]       process_noise;
  logic [CFG_W-1:0]       measurement_noise;
  logic [DATA_W-1:0]      prior_estimate;
  logic [DATA_W-1:0]      error_variance;
  logic [DATA_W-1:0]      p_reg;
  logic [DATA_W:0]        d_reg;
  logic                   d_zero;
  logic signed [DATA_W:0] err_reg;
  logic [DATA_W+1:0]      rem;
  logic [FRAC_BITS:0]     k;
  logic [CW-1:0]          cnt;
  logic signed [PW-1:0]   prod;
  logic [DATA_W-1:0]      out_data;

  logic [DATA_W:0]          p_sum;
  logic [DATA_W-1:0]        p_sat;
  logic signed [DATA_W:0]   err_next;
  logic [DATA_W:0]          d_sum;
  logic                     rem_ge;
  logic [DATA_W+1:0]        rem_sub;
  logic signed [DATA_W:0]   mul_a;
  logic signed [FRAC_BITS+1:0] mul_b;
  logic signed [PW-1:0]     mul_p;
  logic signed [PW-1:0]     rnd;
  logic signed [34:0]       sh;
  logic signed [35:0]       est_sum;
  logic [DATA_W-1:0]        est_sat;
  logic [DATA_W-1:0]        var_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= Q_RESET;
      measurement_noise <= R_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_PROCESS_NOISE:     process_noise     <= cfg_data;
        CFG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  // predict: p = sat32(var + Q), innovation = z - x
  always_comb begin
    p_sum    = {1'b0, error_variance} + {{(DATA_W + 1 - CFG_W){1'b0}}, process_noise};
    p_sat    = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
    err_next = $signed({measurement[DATA_W-1], measurement})
             - $signed({prior_estimate[DATA_W-1], prior_estimate});
    d_sum    = {1'b0, p_reg} + {{(DATA_W + 1 - CFG_W){1'b0}}, measurement_noise};
  end

  // restoring divider: k = floor(p * 2^F / d), MSB first
  always_comb begin
    rem_ge  = rem >= {1'b0, d_reg};
    rem_sub = rem_ge ? (rem - {1'b0, d_reg}) : rem;
  end

  // shared multiplier
  always_comb begin
    if (cmd.upd_est) begin
      mul_a = $signed({1'b0, p_reg});
      mul_b = $signed({1'b0, ONE - k});
    end else begin
      mul_a = err_reg;
      mul_b = $signed({1'b0, k});
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // round to nearest, ties up; upper bits give the floor shift
  always_comb begin
    rnd     = prod + HALF;
    sh      = rnd[PW-1:FRAC_BITS];
    est_sum = 36'(sh) + {{4{prior_estimate[DATA_W-1]}}, prior_estimate};
    if (est_sum[35:31] != 5'b00000 && est_sum[35:31] != 5'b11111) begin
      est_sat = est_sum[35] ? {1'b1, {(DATA_W - 1){1'b0}}} : {1'b0, {(DATA_W - 1){1'b1}}};
    end else begin
      est_sat = est_sum[DATA_W-1:0];
    end
    var_sat = (sh[34:32] != 3'b000) ? '1 : sh[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_estimate <= '0;
      error_variance <= '0;
    end else begin
      if (cmd.upd_est) prior_estimate <= est_sat;
      if (cmd.upd_var) error_variance <= var_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_reg   <= p_sat;
      err_reg <= err_next;
    end
    if (cmd.dinit) begin
      d_reg  <= d_sum;
      d_zero <= (d_sum == '0);
      rem    <= {1'b0, d_sum[DATA_W:0] & '0} | {2'b00, p_reg};
      k      <= '0;
      cnt    <= '0;
    end
    if (cmd.div_step) begin
      rem <= {rem_sub[DATA_W:0], 1'b0};
      k   <= {k[FRAC_BITS-1:0], rem_ge & ~d_zero};
      cnt <= cnt + CW'(1);
    end
    if (cmd.mul_est || cmd.upd_est) begin
      prod <= mul_p;
    end
    if (cmd.out_load) begin
      out_data <= prior_estimate;
    end
  end

  assign status.div_last = (cnt == CW'(FRAC_BITS));
  assign estimate        = out_data;

  `SKF_ASSERT(a_gain_range, clk, rst, cmd.mul_est |-> (k <= ONE), "gain above one")
  `SKF_ASSERT(a_zero_den_gain, clk, rst, (cmd.mul_est && d_zero) |-> (k == '0), "gain not zero on zero denominator")
  `SKF_ASSERT(a_var_shrinks, clk, rst, cmd.upd_var |=> (error_variance <= p_reg), "variance above prediction")

endmodule

// ----- hw/rtl/skf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_ctrl: sequencer for the scalar Kalman filter
// Steps one sample through predict, divide, update; owns the output valid.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_macros.svh"

module skf_ctrl
  import skf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  output logic    m_axis_tvalid,
  input  logic    m_axis_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_free;

  // output register can take a new result when empty or draining now
  assign out_free = ~out_valid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_axis_tvalid) state_next = S_DINIT;
      S_DINIT:   state_next = S_DIV;
      S_DIV:     if (status.div_last) state_next = S_MULK;
      S_MULK:    state_next = S_UPD_EST;
      S_UPD_EST: state_next = S_UPD_VAR;
      S_UPD_VAR: state_next = S_OUT;
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      S_DINIT:   cmd.dinit    = 1'b1;
      S_DIV:     cmd.div_step = 1'b1;
      S_MULK:    cmd.mul_est  = 1'b1;
      S_UPD_EST: cmd.upd_est  = 1'b1;
      S_UPD_VAR: cmd.upd_var  = 1'b1;
      S_OUT:     cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;

  `SKF_ASSERT(a_cmd_onehot, clk, rst, $onehot0(cmd), "more than one datapath command")
  `SKF_ASSERT(a_div_exit, clk, rst, (state == S_DIV && status.div_last) |=> (state == S_MULK), "divider did not finish")
  `SKF_ASSERT(a_out_hold, clk, rst, (state == S_OUT && out_valid && !m_axis_tready) |=> (state == S_OUT), "result overwrote a pending transaction")

endmodule

// ----- hw/rtl/scalar_kalman_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional constant-state Kalman filter
// Signed fixed-point sample in, saturated filtered estimate out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one measurement per transaction (signed, FRAC_BITS
//   fraction bits); m_axis returns one estimate per measurement, in order.
//   The cfg channel writes Q (index 0) and R (index 1), 24 bits unsigned;
//   writes to other indexes are dropped. cfg_ready is always high; write
//   only while no sample is in flight.
// Operation:
//   One sample at a time. After the accept edge the sequencer forms p + R, runs
//   FRAC_BITS+1 restoring division steps for the gain, makes two passes of the
//   shared multiplier, writes the variance and loads the output register.
//   m_axis_tvalid rises as the output register loads; the next sample is
//   taken from the idle state that follows.
// Reset:
//   rst (synchronous) clears estimate and variance to zero, loads Q = 0.03
//   and R = 15.0, empties the output register.
// Back-pressure:
//   The result sits in an output register, so the next sample is accepted
//   and processed while it waits; that sample then holds in the final state
//   until the register is free.
// ----------------------------------------------------------------------------
module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] measurement
  // estimate stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] estimate
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  skf_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .measurement (s_axis_tdata),
    .estimate    (m_axis_tdata)
  );

endmodule

// ----- tb/tb_scalar_kalman_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter: self-checking bench for the scalar Kalman filter
// Streams signed Q16.16 samples in and compares every estimate with a bit-exact
// fixed-point filter kept in a small scoreboard. Covers Q and R from their
// extremes to random values, a zero gain denominator and dropped register
// writes, with random gaps on the sample stream and back-pressure on the estimate stream.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter;
  import skf_pkg::*;

  localparam int              KF_FRAC       = 16;
  localparam longint unsigned GAIN_ONE      = 64'd1 << KF_FRAC;
  localparam longint unsigned ROUND_HALF    = 64'd1 << (KF_FRAC - 1);
  localparam longint          ROUND_HALF_S  = 64'sd1 <<< (KF_FRAC - 1);
  localparam longint          EST_MAX       = 64'sd2147483647;
  localparam longint          EST_MIN       = -64'sd2147483648;
  localparam logic [31:0]     MEAS_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0]     MEAS_MIN      = 32'h8000_0000;
  localparam int              IDLE_LIMIT    = 2000;
  localparam int              RANDOM_PHASES = 10;
  localparam int              PHASE_ITEMS   = 75;

  // --------------------------------------------------------------------------
  // Scoreboard: a bit-exact copy of the filter state and the noise registers.
  // Every accepted sample pushes the estimate it should produce; every
  // accepted estimate is compared with the oldest one waiting.
  // --------------------------------------------------------------------------
  class kalman_scoreboard;
    logic signed [31:0] estimate;
    logic [31:0]        variance;
    logic [CFG_W-1:0]   q_noise;
    logic [CFG_W-1:0]   r_noise;
    logic [DATA_W-1:0]  expected_estimates[$];
    int                 mismatches;
    int                 checked;
    int                 accepted;

    function new();
      estimate   = '0;
      variance   = '0;
      q_noise    = Q_RESET;
      r_noise    = R_RESET;
      mismatches = 0;
      checked    = 0;
      accepted   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_PROCESS_NOISE:     q_noise = data;
        CFG_MEASUREMENT_NOISE: r_noise = data;
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    function void note_measurement(logic [DATA_W-1:0] meas);
      longint unsigned p;
      longint unsigned d;
      longint unsigned k;
      longint unsigned v;
      longint          err;
      longint          corr;
      // predicted variance, held at 2^32-1
      p = variance;
      p = p + q_noise;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      // gain; p + R of zero gives no gain at all
      d = p + r_noise;
      k = (d == 0) ? 64'd0 : (p << KF_FRAC) / d;
      if (k > GAIN_ONE) k = GAIN_ONE;
      // correction rounded to nearest, ties up
      err  = $signed(meas) - estimate;
      corr = (err * longint'(k) + ROUND_HALF_S) >>> KF_FRAC;
      err  = corr + estimate;
      if (err > EST_MAX) err = EST_MAX;
      else if (err < EST_MIN) err = EST_MIN;
      estimate = err[31:0];
      v = (p * (GAIN_ONE - k) + ROUND_HALF) >> KF_FRAC;
      if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
      variance = v[31:0];
      expected_estimates.push_back(estimate);
      accepted++;
    endfunction

    function void check_estimate(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (expected_estimates.size() == 0) begin
        mismatches++;
        $display("%0t: estimate %h arrived with none outstanding", $time, got);
      end else begin
        want = expected_estimates.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t: estimate mismatch, expected %h, actual %h", $time, want, got);
        end
      end
    endfunction

    function int pending();
      return expected_estimates.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata  = '0;   // [31:0] measurement
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;         // [31:0] estimate
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_data      = '0;

  kalman_scoreboard sb = new();

  bit src_free  = 1'b0;  // source sends back to back
  bit sink_free = 1'b0;  // sink never stalls
  int stall_left  = 0;
  int idle_cycles = 0;
  int cfg_writes  = 0;
  int settings    = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  scalar_kalman_filter #(
    .FRAC_BITS(KF_FRAC)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Estimate sink: checks each transaction, then picks tready for the next
  // edge. Stalls are mostly short, now and then a long one.
  // Also keeps the count of cycles with no transaction on any channel.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_estimate(m_axis_tdata);

    if (rst || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end

    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_free || $urandom_range(0, 99) < 70) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 3);
    end
  end

  // gap after a sample: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (src_free || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // tvalid stays high into the next sample when no gap follows
  task automatic send_measurement(input logic [DATA_W-1:0] meas);
    int gap;
    s_axis_tdata  <= meas;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_measurement(meas);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // 'more' keeps cfg_valid high for a write that follows straight on
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] data, input bit more);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_writes++;
    if (!more) cfg_valid <= 1'b0;
  endtask

  // stop the sample stream and wait for every estimate to come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_noise(input bit for_q);
    logic [CFG_W-1:0] n;
    case ($urandom_range(0, 9))
      0:       n = for_q ? 24'd1 : 24'd0;
      1:       n = 24'hFF_FFFF;
      2, 3, 4: n = CFG_W'($urandom_range(1, 4096));
      5, 6:    n = (for_q ? Q_RESET : R_RESET) + CFG_W'($urandom_range(0, 255));
      default: n = CFG_W'($urandom());
    endcase
    if (for_q && n == 0) n = 24'd1;
    return n;
  endfunction

  // new Q and R in random order, now and then a write to a dead index
  task automatic configure_phase();
    logic [CFG_W-1:0] q;
    logic [CFG_W-1:0] r;
    q = pick_noise(1'b1);
    r = pick_noise(1'b0);
    if ($urandom_range(0, 3) == 0)
      write_register(CFG_IDX_W'($urandom_range(2, 15)), CFG_W'($urandom()), 1'b1);
    if ($urandom_range(0, 1) == 1) begin
      write_register(CFG_PROCESS_NOISE, q, 1'b1);
      write_register(CFG_MEASUREMENT_NOISE, r, 1'b0);
    end else begin
      write_register(CFG_MEASUREMENT_NOISE, r, 1'b1);
      write_register(CFG_PROCESS_NOISE, q, 1'b0);
    end
    settings++;
  endtask

  // styles: 0 full range, 1 and 3 noisy level, 2 extremes mixed in
  function automatic logic [DATA_W-1:0] pick_measurement(input int style,
                                                         input logic [DATA_W-1:0] level);
    int                noise;
    logic [DATA_W-1:0] m;
    noise = int'($urandom_range(0, 2097152)) - 1048576;
    case (style)
      0:       m = $urandom();
      1, 3:    m = level + noise;
      default: begin
        case ($urandom_range(0, 5))
          0:       m = MEAS_MAX;
          1:       m = MEAS_MIN;
          2:       m = '0;
          3:       m = '1;
          4:       m = 32'd1;
          default: m = $urandom();
        endcase
      end
    endcase
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [DATA_W-1:0] level;
    int                style;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of Q and R, extremes of the sample range
    send_measurement(32'h0064_0000);
    send_measurement(32'h0064_0000);
    send_measurement(32'h0064_0000);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    send_measurement(32'hFFFF_FFFF);
    send_measurement(32'h0000_0001);
    send_measurement(32'h0000_0000);
    settle();

    // Q = R = 0: first sample takes full gain and clears the variance,
    // after that p + R is zero and the estimate must hold
    write_register(CFG_PROCESS_NOISE, 24'd0, 1'b1);
    write_register(CFG_MEASUREMENT_NOISE, 24'd0, 1'b0);
    settings++;
    send_measurement(32'h1234_5678);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    settle();

    // smallest Q with R = 0: unit gain, widest innovation swings
    write_register(CFG_PROCESS_NOISE, 24'd1, 1'b0);
    settings++;
    send_measurement(MEAS_MIN);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    send_measurement(32'hA5A5_A5A5);
    settle();

    // largest Q and R
    write_register(CFG_PROCESS_NOISE, 24'hFF_FFFF, 1'b1);
    write_register(CFG_MEASUREMENT_NOISE, 24'hFF_FFFF, 1'b0);
    settings++;
    send_measurement(32'h5A5A_5A5A);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    settle();

    // every unmapped index must leave Q and R alone
    for (int idx = 2; idx < 16; idx++)
      write_register(CFG_IDX_W'(idx), CFG_W'($urandom()), idx != 15);
    send_measurement(32'h0001_0000);
    send_measurement(32'hFFFF_0000);
    settle();

    write_register(CFG_MEASUREMENT_NOISE, R_RESET, 1'b1);
    write_register(CFG_PROCESS_NOISE, Q_RESET, 1'b0);
    settings++;
    send_measurement(32'h0010_8000);
    send_measurement(32'h0010_0000);
    send_measurement(32'hFFEF_8000);

    // random phases, each under its own Q and R
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      configure_phase();
      src_free  = (ph % 4 == 1);
      sink_free <= (ph % 4 == 2);
      style = ph % 4;
      level = $urandom();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (style == 3 && i % 16 == 0) level = $urandom();
        send_measurement(pick_measurement(style, level));
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d estimates never arrived", $time, sb.pending());
    end

    $display("%0d samples sent, %0d estimates checked, %0d mismatches",
             sb.accepted, sb.checked, sb.mismatches);
    $display("%0d register writes over %0d noise settings", cfg_writes, settings);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog: too long with no transaction anywhere
  initial begin
    wait (!rst);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/skf_pkg.sv
hw/rtl/skf_datapath.sv
hw/rtl/skf_ctrl.sv
hw/rtl/scalar_kalman_filter.sv
tb/tb_scalar_kalman_filter.sv
